[hdl/crcfr_pkg.sv]
// Package for the CRC-checked frame receiver.
// Holds the phase encoding, status codes, result layout and CRC-32 constants.
// No dependencies.
package crcfr_pkg;

    // CRC-32, reflected form
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

    // Reset values of the marker registers
    localparam logic [7:0] START_MARKER_RST = 8'hAA;
    localparam logic [7:0] END_MARKER_RST   = 8'hBB;

    // Configuration register indexes
    localparam logic CFG_START_MARKER = 1'b0;
    localparam logic CFG_END_MARKER   = 1'b1;

    // Largest length that the report field can show
    localparam logic [15:0] LEN_SAT = 16'd2047;

    // Result kinds (travel on tuser)
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_REPORT  = 1'b1;

    // Frame status codes
    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_BADSTART = 3'd1,
        ST_TOOLONG  = 3'd2,
        ST_CRCBAD   = 3'd3,
        ST_BADEND   = 3'd4
    } t_status;

    // Receiver phase, one-hot
    typedef enum logic [6:0] {
        PH_HUNT    = 7'b000_0001,
        PH_TYPE    = 7'b000_0010,
        PH_LEN_HI  = 7'b000_0100,
        PH_LEN_LO  = 7'b000_1000,
        PH_PAYLOAD = 7'b001_0000,
        PH_CRC     = 7'b010_0000,
        PH_END     = 7'b100_0000
    } t_phase;

    // Result item as packed into tdata, first field highest, last field lowest
    typedef struct packed {
        logic [1:0]  pad;
        t_status     frame_status;
        logic [10:0] frame_length;
        logic [7:0]  frame_type;
        logic [7:0]  payload_byte;
    } t_result;

endpackage

[hdl/crc_checked_frame_receiver_top.sv]
// Top level of the CRC-checked frame receiver.
// Depends on crcfr_pkg and crcfr_crc_byte.
//
// Takes received serial bytes and parses frames of the form: start marker,
// type, 16-bit length (high byte first), payload, CRC-32 (low byte first),
// end marker. Each payload byte goes out as it arrives (tuser = 0); the end of
// a frame, or any error, gives a report (tuser = 1) with type, length
// (saturated to 2047) and status: 0 ok, 1 bad start, 2 length too large,
// 3 CRC mismatch, 4 bad end. Every byte outside a frame other than the start
// marker gives a bad-start report. The block takes one byte per clock unless a
// held result stalls it; a byte's result passes through the input register,
// then the result register. The per-byte CRC update is an eight-step unrolled
// loop that settles combinationally between those registers. A result held
// by the master side stalls the input only while the byte behind it also has
// a result. The user must write the marker registers through the configuration
// port while no byte is in flight, not enforced by the block.
module crc_checked_frame_receiver_top
    import crcfr_pkg::*;
#(
    parameter int MAX_PAYLOAD = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration writes
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [7:0]  i_cfg_data,
    // received bytes
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    // results
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [7:0] payload_byte, [15:8] frame_type,
                                        // [26:16] frame_length, [29:27] frame_status
    output logic        m_axis_tuser    // result_kind
);

    localparam int          CW      = $clog2(MAX_PAYLOAD + 1);
    localparam logic [15:0] MAX_LEN = 16'(MAX_PAYLOAD);

    // Configuration registers
    logic [7:0] r_start_marker;
    logic [7:0] r_end_marker;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_marker <= START_MARKER_RST;
            r_end_marker   <= END_MARKER_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_START_MARKER: r_start_marker <= i_cfg_data;
                CFG_END_MARKER:   r_end_marker   <= i_cfg_data;
                default:          ;
            endcase
        end
    end

    // Input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       advance;
    logic       out_free;
    logic       has_res;

    assign out_free      = !m_axis_tvalid || m_axis_tready;
    assign advance       = r_in_valid && (!has_res || out_free);
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    // Frame state
    t_phase        r_phase;
    logic [31:0]   r_crc;
    logic [31:0]   r_rx_crc;
    logic [15:0]   r_len;
    logic [CW-1:0] r_remain;
    logic [7:0]    r_type;
    logic [1:0]    r_crc_idx;

    t_phase        n_phase;
    logic [31:0]   n_crc;
    logic [31:0]   n_rx_crc;
    logic [15:0]   n_len;
    logic [CW-1:0] n_remain;
    logic [7:0]    n_type;
    logic [1:0]    n_crc_idx;

    logic [31:0] crc_base;
    logic [31:0] crc_upd;
    logic [15:0] len_full;
    logic [15:0] len_sat_src;
    logic [10:0] len_sat;
    logic        res_kind;
    t_result     res;

    // Start marker restarts the CRC from its initial value
    assign crc_base = (r_phase == PH_TYPE || r_phase == PH_LEN_HI ||
                       r_phase == PH_LEN_LO || r_phase == PH_PAYLOAD) ? r_crc : CRC_INIT;

    crcfr_crc_byte u_crc (
        .i_crc  (crc_base),
        .i_byte (r_in_byte),
        .o_crc  (crc_upd)
    );

    // Length as it stands after the low byte, and its saturated report value
    assign len_full    = {r_len[15:8], r_in_byte};
    assign len_sat_src = (r_phase == PH_LEN_LO) ? len_full : r_len;
    assign len_sat     = (len_sat_src > LEN_SAT) ? LEN_SAT[10:0] : len_sat_src[10:0];

    // Per-byte parser step
    always_comb begin
        n_phase   = r_phase;
        n_crc     = r_crc;
        n_rx_crc  = r_rx_crc;
        n_len     = r_len;
        n_remain  = r_remain;
        n_type    = r_type;
        n_crc_idx = r_crc_idx;
        has_res   = 1'b0;
        res_kind  = KIND_REPORT;
        res.pad          = 2'd0;
        res.payload_byte = 8'd0;
        res.frame_type   = r_type;
        res.frame_length = len_sat;
        res.frame_status = ST_OK;

        unique case (r_phase)
            PH_TYPE: begin
                n_type  = r_in_byte;
                n_crc   = crc_upd;
                n_phase = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                n_len   = {r_in_byte, 8'd0};
                n_crc   = crc_upd;
                n_phase = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                n_len = len_full;
                n_crc = crc_upd;
                if (len_full > MAX_LEN) begin
                    n_phase          = PH_HUNT;
                    has_res          = 1'b1;
                    res.frame_status = ST_TOOLONG;
                end else begin
                    n_remain  = len_full[CW-1:0];
                    n_crc_idx = 2'd0;
                    n_rx_crc  = 32'd0;
                    n_phase   = (len_full == 16'd0) ? PH_CRC : PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                n_crc    = crc_upd;
                n_remain = r_remain - CW'(1);
                if (r_remain == CW'(1)) begin
                    n_phase = PH_CRC;
                end
                has_res          = 1'b1;
                res_kind         = KIND_PAYLOAD;
                res.payload_byte = r_in_byte;
            end
            PH_CRC: begin
                // received low byte first: shift in from the top
                n_rx_crc  = {r_in_byte, r_rx_crc[31:8]};
                n_crc_idx = r_crc_idx + 2'd1;
                if (r_crc_idx == 2'd3) begin
                    n_phase = PH_END;
                end
            end
            PH_END: begin
                n_phase = PH_HUNT;
                has_res = 1'b1;
                if (r_in_byte != r_end_marker) begin
                    res.frame_status = ST_BADEND;
                end else if (~r_crc != r_rx_crc) begin
                    res.frame_status = ST_CRCBAD;
                end else begin
                    res.frame_status = ST_OK;
                end
            end
            default: begin
                // hunting for a start marker
                n_phase = PH_HUNT;
                if (r_in_byte != r_start_marker) begin
                    has_res          = 1'b1;
                    res.frame_type   = 8'd0;
                    res.frame_length = 11'd0;
                    res.frame_status = ST_BADSTART;
                end else begin
                    n_crc     = crc_upd;
                    n_rx_crc  = 32'd0;
                    n_len     = 16'd0;
                    n_remain  = '0;
                    n_type    = 8'd0;
                    n_crc_idx = 2'd0;
                    n_phase   = PH_TYPE;
                end
            end
        endcase
    end

    // State update on each processed byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HUNT;
            r_crc     <= CRC_INIT;
            r_rx_crc  <= 32'd0;
            r_len     <= 16'd0;
            r_remain  <= '0;
            r_type    <= 8'd0;
            r_crc_idx <= 2'd0;
        end else if (advance) begin
            r_phase   <= n_phase;
            r_crc     <= n_crc;
            r_rx_crc  <= n_rx_crc;
            r_len     <= n_len;
            r_remain  <= n_remain;
            r_type    <= n_type;
            r_crc_idx <= n_crc_idx;
        end
    end

    // Result register
    logic    r_out_valid;
    logic    r_out_kind;
    t_result r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && has_res) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && has_res) begin
            r_out_kind <= res_kind;
            r_out      <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;
    assign m_axis_tuser  = r_out_kind;

endmodule

[hdl/crcfr_crc_byte.sv]
// One-byte update of the reflected CRC-32 (polynomial 0xEDB88320).
// Eight bit steps unrolled into one combinational pass.
// Depends on crcfr_pkg.
module crcfr_crc_byte
    import crcfr_pkg::*;
(
    input  logic [31:0] i_crc,
    input  logic [7:0]  i_byte,
    output logic [31:0] o_crc
);

    // Shift out eight bits, folding in the polynomial on a set LSB
    always_comb begin
        logic [31:0] v_crc;
        v_crc = i_crc ^ {24'd0, i_byte};
        for (int k = 0; k < 8; k++) begin
            if (v_crc[0]) begin
                v_crc = (v_crc >> 1) ^ CRC_POLY;
            end else begin
                v_crc = v_crc >> 1;
            end
        end
        o_crc = v_crc;
    end

endmodule

[bench/tb.sv]
`timescale 1ns / 100ps
// Testbench for crc_checked_frame_receiver_top: sends good, corrupted and cut
// frames mixed with line noise, and checks every result against a frame parser
// kept in the bench. Depends on crcfr_pkg and the receiver RTL.
module tb
    import crcfr_pkg::*;
();

    localparam int MAX_PAYLOAD         = 1024;
    localparam int BYTES_PER_SETTING   = 350;
    localparam int DRAIN_LIMIT         = 5000;
    localparam int REPORTED_MISMATCHES = 10;

    // How a sent frame is spoiled
    typedef enum {FLAW_NONE, FLAW_CRC, FLAW_END, FLAW_CUT} t_flaw;

    // One result as it should leave the block
    typedef struct packed {
        logic    kind;
        t_result data;
    } t_due;

    // Frame parser plus the list of results it still waits for
    class frame_scoreboard;
        logic [7:0]  start_mark;
        logic [7:0]  end_mark;
        t_phase      ph;
        logic [31:0] crc;
        logic [31:0] rx_crc;
        logic [15:0] ann_len;
        logic [15:0] remaining;
        logic [7:0]  held_type;
        logic [1:0]  crc_idx;
        t_due        results_due[$];
        int unsigned failures;

        function new();
            start_mark = START_MARKER_RST;
            end_mark   = END_MARKER_RST;
            ph         = PH_HUNT;
            crc        = CRC_INIT;
            rx_crc     = '0;
            ann_len    = '0;
            remaining  = '0;
            held_type  = '0;
            crc_idx    = '0;
            failures   = 0;
        endfunction

        // Reflected CRC-32, one byte
        static function logic [31:0] crc_update(logic [31:0] c, logic [7:0] b);
            c ^= {24'd0, b};
            for (int k = 0; k < 8; k++)
                c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
            return c;
        endfunction

        function void set_marker(logic idx, logic [7:0] value);
            if (idx == CFG_START_MARKER)
                start_mark = value;
            else
                end_mark = value;
        endfunction

        function void flag(string what);
            failures++;
            if (failures <= REPORTED_MISMATCHES)
                $display("%0t: %s", $realtime, what);
        endfunction

        function logic [10:0] shown_length();
            return (ann_len > LEN_SAT) ? LEN_SAT[10:0] : ann_len[10:0];
        endfunction

        function void add_result(logic kind, logic [7:0] pbyte, logic [7:0] ftype,
                                 logic [10:0] flen, t_status st);
            t_due d;
            d.kind              = kind;
            d.data.pad          = '0;
            d.data.frame_status = st;
            d.data.frame_length = flen;
            d.data.frame_type   = ftype;
            d.data.payload_byte = pbyte;
            results_due.push_back(d);
        endfunction

        // Advance the parser by one accepted byte
        function void parse_byte(logic [7:0] b);
            t_status st;
            case (ph)
                PH_TYPE: begin
                    held_type = b;
                    crc = crc_update(crc, b);
                    ph = PH_LEN_HI;
                end
                PH_LEN_HI: begin
                    ann_len = {b, 8'h00};
                    crc = crc_update(crc, b);
                    ph = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    ann_len[7:0] = b;
                    crc = crc_update(crc, b);
                    if (ann_len > MAX_PAYLOAD) begin
                        ph = PH_HUNT;
                        add_result(KIND_REPORT, 8'h00, held_type, shown_length(), ST_TOOLONG);
                    end else begin
                        remaining = ann_len;
                        crc_idx = '0;
                        rx_crc = '0;
                        ph = (ann_len == 0) ? PH_CRC : PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    crc = crc_update(crc, b);
                    remaining--;
                    if (remaining == 0)
                        ph = PH_CRC;
                    add_result(KIND_PAYLOAD, b, held_type, shown_length(), ST_OK);
                end
                PH_CRC: begin
                    // FCS arrives low byte first
                    rx_crc[crc_idx*8 +: 8] = b;
                    if (crc_idx == 2'd3)
                        ph = PH_END;
                    crc_idx++;
                end
                PH_END: begin
                    // a wrong end marker wins over a CRC mismatch
                    if (b != end_mark)
                        st = ST_BADEND;
                    else if (~crc != rx_crc)
                        st = ST_CRCBAD;
                    else
                        st = ST_OK;
                    ph = PH_HUNT;
                    add_result(KIND_REPORT, 8'h00, held_type, shown_length(), st);
                end
                default: begin
                    ph = PH_HUNT;
                    if (b != start_mark) begin
                        add_result(KIND_REPORT, 8'h00, 8'h00, 11'd0, ST_BADSTART);
                    end else begin
                        crc = crc_update(CRC_INIT, b);
                        rx_crc = '0;
                        ann_len = '0;
                        remaining = '0;
                        held_type = '0;
                        crc_idx = '0;
                        ph = PH_TYPE;
                    end
                end
            endcase
        endfunction

        function void check_result(logic kind, logic [31:0] data);
            t_result got;
            t_due    want;
            got = t_result'(data);
            if (results_due.size() == 0) begin
                flag($sformatf("unexpected result: kind %0d data %h", kind, data));
                return;
            end
            want = results_due.pop_front();
            if (kind !== want.kind || got.pad !== 2'b00
                    || got.payload_byte !== want.data.payload_byte
                    || got.frame_type !== want.data.frame_type
                    || got.frame_length !== want.data.frame_length
                    || got.frame_status !== want.data.frame_status)
                flag($sformatf({"mismatch: expected kind %0d byte %h type %h len %0d ",
                                "status %0d, got kind %0d byte %h type %h len %0d ",
                                "status %0d pad %b"},
                               want.kind, want.data.payload_byte, want.data.frame_type,
                               want.data.frame_length, want.data.frame_status,
                               kind, got.payload_byte, got.frame_type,
                               got.frame_length, got.frame_status, got.pad));
        endfunction

        function void flush_missing();
            t_due d;
            while (results_due.size() != 0) begin
                d = results_due.pop_front();
                flag($sformatf("missing result: kind %0d byte %h type %h len %0d status %0d",
                               d.kind, d.data.payload_byte, d.data.frame_type,
                               d.data.frame_length, d.data.frame_status));
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_idx;
    logic [7:0]  i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;    // [7:0] rx_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;    // [7:0] payload_byte, [15:8] frame_type,
                                  // [26:16] frame_length, [29:27] frame_status
    logic        m_axis_tuser;    // result_kind

    frame_scoreboard sb;
    bit              no_gaps;
    int unsigned     tx_count;

    crc_checked_frame_receiver_top #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Result side backpressure
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            m_axis_tready = no_gaps || ($urandom_range(99) >= 31);
        end
    end

    // Result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tuser, m_axis_tdata);
    end

    // Run limit
    initial begin
        #10_000_000;
        $display("crc_checked_frame_receiver_top test failed");
        $finish;
    end

    // One byte transfer, with random idle cycles ahead of it
    task automatic send_byte(input logic [7:0] b);
        @(negedge i_clk);
        while (!no_gaps && $urandom_range(99) < 31) begin
            s_axis_tvalid = 1'b0;
            s_axis_tdata  = 8'($urandom);
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = b;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.parse_byte(b);
        tx_count++;
    endtask

    // Whole frame with the current markers; the flaw spoils it
    task automatic send_frame(input logic [7:0] ftype, input logic [15:0] len,
                              input t_flaw flaw);
        logic [31:0] fcs;
        logic [7:0]  hdr [4];
        logic [7:0]  b;
        int unsigned cut;
        hdr[0] = sb.start_mark;
        hdr[1] = ftype;
        hdr[2] = len[15:8];
        hdr[3] = len[7:0];
        fcs = CRC_INIT;
        for (int i = 0; i < 4; i++) begin
            fcs = frame_scoreboard::crc_update(fcs, hdr[i]);
            send_byte(hdr[i]);
        end
        if (len > MAX_PAYLOAD)
            return;
        cut = (flaw == FLAW_CUT && len != 0) ? $urandom_range(len - 1) : len;
        for (int i = 0; i < cut; i++) begin
            b = 8'($urandom);
            fcs = frame_scoreboard::crc_update(fcs, b);
            send_byte(b);
        end
        if (flaw == FLAW_CUT)
            return;
        fcs = ~fcs;
        if (flaw == FLAW_CRC)
            fcs[$urandom_range(31)] ^= 1'b1;
        for (int i = 0; i < 4; i++)
            send_byte(fcs[i*8 +: 8]);
        send_byte(flaw == FLAW_END ? sb.end_mark ^ 8'($urandom_range(1, 255)) : sb.end_mark);
    endtask

    // Let every pending result out, then give the pipeline time to empty
    task automatic drain();
        int unsigned n;
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        n = 0;
        while (sb.results_due.size() != 0 && n < DRAIN_LIMIT) begin
            @(posedge i_clk);
            n++;
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_marker(input logic idx, input logic [7:0] value);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = value;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        sb.set_marker(idx, value);
    endtask

    // Mostly well-formed frames with random content, plus noise and spoiled frames
    task automatic run_random(input int unsigned count, input bit full_first);
        int unsigned stop_at;
        int unsigned r;
        int unsigned r_len;
        logic [15:0] len;
        t_flaw       flaw;
        stop_at = tx_count + count;
        if (full_first)
            send_frame(8'($urandom), 16'(MAX_PAYLOAD), FLAW_NONE);
        while (tx_count < stop_at) begin
            r = $urandom_range(99);
            if (r < 10) begin
                send_byte(8'($urandom));
            end else begin
                r_len = $urandom_range(99);
                if (r < 18)
                    len = ($urandom_range(3) == 0) ? 16'(MAX_PAYLOAD + 1)
                                                   : 16'($urandom_range(MAX_PAYLOAD + 1, 65535));
                else if (r_len < 93)
                    len = 16'($urandom_range(15));
                else if (r_len < 99)
                    len = 16'($urandom_range(16, 100));
                else
                    len = 16'($urandom_range(101, MAX_PAYLOAD));
                if (r < 28)
                    flaw = FLAW_CRC;
                else if (r < 38)
                    flaw = FLAW_END;
                else if (r < 45)
                    flaw = FLAW_CUT;
                else
                    flaw = FLAW_NONE;
                send_frame(8'($urandom), len, flaw);
            end
        end
    endtask

    // Main sequence
    initial begin
        logic [7:0] start_set [5];
        logic [7:0] end_set [5];
        start_set[0] = START_MARKER_RST;  end_set[0] = END_MARKER_RST;
        start_set[1] = 8'h00;             end_set[1] = 8'hFF;
        start_set[2] = 8'hFF;             end_set[2] = 8'h00;
        start_set[3] = 8'($urandom);      end_set[3] = 8'($urandom);
        start_set[4] = 8'h5A;             end_set[4] = 8'h5A;

        sb            = new();
        no_gaps       = 1'b0;
        tx_count      = 0;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = CFG_START_MARKER;
        i_cfg_data    = 8'h00;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: noise byte, zero-length frame with a bad CRC,
        // one-byte frame with a bad end marker, length beyond the limit
        send_byte(8'h00);
        send_frame(8'h00, 16'd0, FLAW_CRC);
        send_frame(8'hFF, 16'd1, FLAW_END);
        send_frame(8'hA5, 16'hFFFF, FLAW_NONE);

        for (int s = 0; s < 5; s++) begin
            if (s != 0) begin
                drain();
                write_marker(CFG_START_MARKER, start_set[s]);
                write_marker(CFG_END_MARKER, end_set[s]);
            end
            no_gaps = (s == 2);
            run_random(BYTES_PER_SETTING, s == 1);
        end
        no_gaps = 1'b0;

        drain();
        repeat (8) @(posedge i_clk);
        sb.flush_missing();
        if (sb.failures == 0)
            $display("crc_checked_frame_receiver_top test passed");
        else
            $display("crc_checked_frame_receiver_top test failed");
        $finish;
    end

endmodule
